// ===== rtl/sres_pkg.sv =====
// Shared constants and types for the sensor rising-edge scanner.
// No dependencies; imported by sres_scan and sensor_rising_edge_scanner.
package sres_pkg;

    localparam int WORD_BITS     = 16;
    localparam int POS_W         = 4;
    localparam int BANK_IDX_W    = 3;
    localparam int SENSOR_W      = 5;
    localparam int NUM_BANKS_DEF = 5;

    // Work handed from the bank store to the bit scanner.
    typedef struct packed {
        logic [WORD_BITS-1:0]  rising;
        logic [BANK_IDX_W-1:0] bank;
    } scan_load_t;

endpackage

// ===== rtl/sres_scan.sv =====
// Bit-serial scanner: walks a rising-bit mask one bit per cycle unless stalled, LSB first,
// and emits one event per set bit through an output register. Uses sres_pkg.
module sres_scan
    import sres_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  scan_load_t            load_data,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BANK_IDX_W-1:0] bank_index,
    output logic [SENSOR_W-1:0]   sensor_number,
    output logic                  last_event
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                  state_reg, state_next;
    logic [WORD_BITS-1:0]  shift_reg, shift_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [BANK_IDX_W-1:0] bank_reg, bank_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BANK_IDX_W-1:0] out_bank_reg, out_bank_next;
    logic [SENSOR_W-1:0]   out_num_reg, out_num_next;
    logic                  out_last_reg, out_last_next;

    logic                  stall;
    logic                  emit;
    logic [WORD_BITS-1:0]  shifted;

    assign shifted = shift_reg >> 1;
    // Hold the scan while a set bit waits for a free output slot.
    assign stall   = shift_reg[0] && out_valid_reg && !out_ready;
    assign emit    = (state_reg == ST_SCAN) && shift_reg[0] && !stall;

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        bank_next      = bank_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_bank_next  = out_bank_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    shift_next = load_data.rising;
                    pos_next   = '0;
                    bank_next  = load_data.bank;
                    state_next = (load_data.rising != '0) ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    shift_next = shifted;
                    pos_next   = pos_reg + 1'b1;
                    if (shifted == '0)
                        state_next = ST_IDLE;
                end
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_bank_next  = bank_reg;
                    out_num_next   = SENSOR_W'(WORD_BITS) - {1'b0, pos_reg};
                    out_last_next  = (shifted == '0);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg     <= bank_next;
        out_bank_reg <= out_bank_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

    assign busy          = (state_reg == ST_SCAN);
    assign out_valid     = out_valid_reg;
    assign bank_index    = out_bank_reg;
    assign sensor_number = out_num_reg;
    assign last_event    = out_last_reg;

    a_scan_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) == (shift_reg != '0))
        else $error("scan state and remaining mask disagree");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (shifted == '0)) |=> (state_reg == ST_IDLE))
        else $error("scan continued after last event");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_num_reg)))
        else $error("pending event overwritten");

endmodule

// ===== rtl/sensor_rising_edge_scanner.sv =====
// Top level of the sensor rising-edge scanner: per-bank word store, bank
// pointer and armed register. Uses sres_pkg and sres_scan.
//
// Usage: each item on the input channel (in_valid/in_ready, sensor_word)
// is one 16-bit sensor word for the bank the internal pointer selects;
// the pointer steps through banks 0..NUM_BANKS-1 and wraps. Every bit that
// rose since that bank's previous word yields one item on the output
// channel (out_valid/out_ready): bank_index, sensor_number = 16 - bit
// position, lowest bit first, last_event set on the final one.
// armed is written through armed_wr_en/armed_wr_data; while it is 0 input
// items are accepted and dropped with no change of state.
// Throughput: the bit scanner shifts the mask one bit a cycle while the
// output register is free or the current bit is clear, scanning every
// bit up to and including the word's highest rising bit; each event is
// held in the output register while it is presented. A word with no
// rising bit starts no scan. in_ready is low while a scan is running, so
// a new word is not taken until the scan of the last one is done.
// Reset clears all stored words, the pointer and armed. When the receiver
// stalls, the scan holds at the next set bit and resumes when the output
// register drains.
module sensor_rising_edge_scanner
    import sres_pkg::*;
#(
    parameter int NUM_BANKS = NUM_BANKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  armed_wr_en,
    input  logic                  armed_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_BITS-1:0]  sensor_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BANK_IDX_W-1:0] bank_index,
    output logic [SENSOR_W-1:0]   sensor_number,
    output logic                  last_event
);

    localparam int PTR_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_BANKS - 1);

    logic                  armed_reg;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [WORD_BITS-1:0]  prev_reg [NUM_BANKS];
    logic                  busy;
    logic                  accept;
    logic                  take;
    scan_load_t            load_data;
    logic [BANK_IDX_W+PTR_W-1:0] bank_wide;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    // Drop the item when not armed.
    assign take     = accept && armed_reg;

    assign bank_wide = {{BANK_IDX_W{1'b0}}, ptr_reg};
    assign ptr_next  = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;

    assign load_data.rising = sensor_word & ~prev_reg[ptr_reg];
    assign load_data.bank   = bank_wide[BANK_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            ptr_reg   <= '0;
            for (int i = 0; i < NUM_BANKS; i++)
                prev_reg[i] <= '0;
        end
        else
        begin
            if (armed_wr_en)
                armed_reg <= armed_wr_data;
            if (take)
            begin
                prev_reg[ptr_reg] <= sensor_word;
                ptr_reg           <= ptr_next;
            end
        end
    end

    sres_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take),
        .load_data     (load_data),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bank_index    (bank_index),
        .sensor_number (sensor_number),
        .last_event    (last_event)
    );

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_LAST)
        else $error("bank pointer out of range");

    a_unarmed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !armed_reg) |=> ($stable(ptr_reg) && !busy))
        else $error("unarmed item changed state");

    a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (ptr_reg == $past(ptr_next)))
        else $error("bank pointer did not advance");

endmodule

// ===== bench/tb_sensor_rising_edge_scanner.sv =====
// Testbench for sensor_rising_edge_scanner: sends sensor words with random gaps and stalls,
// predicts the rising-edge events per bank and checks every event in order.
// Depends on sres_pkg and the sensor_rising_edge_scanner RTL.
module tb_sensor_rising_edge_scanner;
    import sres_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANKS        = NUM_BANKS_DEF;
    localparam int SCAN_TAIL    = 24;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_WORDS = 480;

    typedef struct packed {
        logic [BANK_IDX_W-1:0] bank;
        logic [SENSOR_W-1:0]   sensor;
        logic                  last;
    } sensor_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  armed_wr_en;
    logic                  armed_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [WORD_BITS-1:0]  sensor_word;
    logic                  out_valid;
    logic                  out_ready;
    logic [BANK_IDX_W-1:0] bank_index;
    logic [SENSOR_W-1:0]   sensor_number;
    logic                  last_event;

    // Predictor state
    logic [WORD_BITS-1:0] stored_words [BANKS];
    int                   bank_ptr;
    logic                 armed_model;
    sensor_event_t        events_due[$];

    int  mismatches = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    sensor_rising_edge_scanner #(
        .NUM_BANKS(BANKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .armed_wr_en   (armed_wr_en),
        .armed_wr_data (armed_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sensor_word   (sensor_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bank_index    (bank_index),
        .sensor_number (sensor_number),
        .last_event    (last_event)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sensor_rising_edge_scanner verification failed");
            $finish;
        end
    end

    // Mostly zero, sometimes a short gap, rarely a long pause.
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(30, 10);
    endfunction

    // Work out the events one accepted word causes and, when armed, advance the bank state.
    function automatic void predict_word(input logic [WORD_BITS-1:0] word);
        logic [WORD_BITS-1:0] rising;
        int                   bank;
        sensor_event_t        ev;
        if (!armed_model)
            return;
        bank = (bank_ptr >= BANKS) ? 0 : bank_ptr;
        rising = word & ~stored_words[bank];
        for (int p = 0; p < WORD_BITS; p++)
        begin
            if (rising[p])
            begin
                ev.bank   = BANK_IDX_W'(bank);
                ev.sensor = SENSOR_W'(WORD_BITS - p);
                ev.last   = ((rising >> (p + 1)) == '0);
                events_due.push_back(ev);
            end
        end
        stored_words[bank] = word;
        bank_ptr = (bank + 1 >= BANKS) ? 0 : bank + 1;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid low.
    task automatic send_word(input logic [WORD_BITS-1:0] word);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        sensor_word = word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(word);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (events_due.size() != 0)
            @(negedge clk);
        // a word with no rising bit may still be in flight
        repeat (SCAN_TAIL) @(negedge clk);
    endtask

    task automatic set_armed(input logic value);
        wait_idle();
        armed_wr_en   = 1'b1;
        armed_wr_data = value;
        @(negedge clk);
        armed_wr_en   = 1'b0;
        armed_model   = value;
    endtask

    // Receiver: random stalls on out_ready.
    always @(negedge clk)
    begin
        if (stall_left == 0)
            stall_left = idle_len();
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else
            out_ready = 1'b1;
    end

    always @(posedge clk)
    begin
        sensor_event_t ev;
        if (rst_n && out_valid && out_ready)
        begin
            if (events_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected event: bank %0d sensor %0d last %0b",
                             bank_index, sensor_number, last_event);
                mismatches++;
            end
            else
            begin
                ev = events_due.pop_front();
                if (bank_index !== ev.bank || sensor_number !== ev.sensor
                    || last_event !== ev.last)
                begin
                    if (mismatches < 10)
                        $display("event mismatch: expected bank %0d sensor %0d last %0b, got bank %0d sensor %0d last %0b",
                                 ev.bank, ev.sensor, ev.last,
                                 bank_index, sensor_number, last_event);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_ignored_while_disarmed();
        set_armed(1'b0);
        send_word(16'hFFFF);
        send_word(16'h8001);
        send_word(16'h0000);
        set_armed(1'b1);
    endtask

    // All-ones, single end bits, no-rise words and a full pointer wrap.
    task automatic test_edge_extremes();
        logic [WORD_BITS-1:0] words [12] = '{
            16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'hAAAA, 16'hFFFF,
            16'h5555, 16'h7FFF, 16'hFFFF, 16'h5555, 16'h0000, 16'hFFFF
        };
        foreach (words[i])
            send_word(words[i]);
    endtask

    // Pointer and stored words must hold while disarmed.
    task automatic test_hold_while_disarmed();
        set_armed(1'b0);
        send_word(16'hFFFF);
        send_word(16'h0F0F);
        set_armed(1'b1);
        set_armed(1'b1);
        send_word(16'hFFFF);
        send_word(16'hF0F0);
        send_word(16'h0001);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word();
        logic [WORD_BITS-1:0] held;
        logic [WORD_BITS-1:0] one_hot;
        int                   r;
        held    = stored_words[(bank_ptr >= BANKS) ? 0 : bank_ptr];
        one_hot = 16'h0001 << $urandom_range(WORD_BITS - 1);
        r = $urandom_range(99);
        if (r < 30)
            return WORD_BITS'($urandom());
        if (r < 45)
            return one_hot;
        if (r < 52)
            return '0;
        if (r < 60)
            return '1;
        if (r < 78)
            return ~held;
        if (r < 90)
            return held | one_hot;
        return held & WORD_BITS'($urandom());
    endfunction

    task automatic test_random_traffic();
        int sent;
        int noise;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent % 60 == 0)
                no_idle = ($urandom_range(3) == 0);
            // drop a burst of ignored words in now and then
            if (sent != 0 && sent % 160 == 0)
            begin
                set_armed(1'b0);
                noise = $urandom_range(6, 2);
                repeat (noise) send_word(WORD_BITS'($urandom()));
                set_armed(1'b1);
            end
            send_word(pick_word());
            sent++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        armed_wr_en   = 1'b0;
        armed_wr_data = 1'b0;
        in_valid      = 1'b0;
        sensor_word   = '0;
        out_ready     = 1'b0;
        foreach (stored_words[i])
            stored_words[i] = '0;
        bank_ptr    = 0;
        armed_model = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ignored_while_disarmed();
        test_edge_extremes();
        test_hold_while_disarmed();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0 && events_due.size() == 0)
            $display("sensor_rising_edge_scanner verification clean");
        else
            $display("sensor_rising_edge_scanner verification failed");
        $finish;
    end

endmodule
